### sv/assert_macros.svh
// Assertion macros used by the checker file olie_checker.sv.
// Both macros expect a signal named clk in the enclosing scope; CHK_ACTIVE also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ACTIVE(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("olie check failed");

// checked at every edge, reset included
`define CHK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("olie check failed");

`endif

### sv/olie_pkg.sv
// Package for the ordered list engine: opcodes, status codes, FSM states
// and the control struct broadcast to the cell chain. No dependencies.
`timescale 1ns / 1ps

package olie_pkg;

  typedef enum logic [2:0] {
    OP_INSERT       = 3'd0,
    OP_REMOVE_AT    = 3'd1,
    OP_READ_AT      = 3'd2,
    OP_PUSH_BACK    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE_MATCH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ERR      = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_MATCH
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       scan_load;
    logic       scan_step;
    logic       match_scan;
  } cell_ctl_t;

endpackage

### sv/olie_cell.sv
// One list cell: holds one entry and its scan word, shifts with neighbors.
// Depends on olie_pkg.
`timescale 1ns / 1ps

module olie_cell #(
  parameter int unsigned K  = 0,
  parameter int unsigned EW = 32,
  parameter int unsigned PW = 7
) (
  input  logic                clk,
  input  olie_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]       tgt,
  input  logic [PW-1:0]       cnt,
  input  logic [EW-1:0]       key,
  input  logic [EW-1:0]       left_entry,
  input  logic [EW-1:0]       right_entry,
  input  logic                right_sfx,
  input  logic                nb_flag,
  input  logic [EW-1:0]       nb_data,
  output logic [EW-1:0]       entry_r,
  output logic                sflag_r,
  output logic [EW-1:0]       sdata_r
);

  localparam logic [PW-1:0] IDX = PW'(K);

  logic [EW-1:0] entry_nxt;
  logic          sflag_nxt;
  logic [EW-1:0] sdata_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      olie_pkg::CM_INSERT: begin
        if (IDX == tgt) begin
          entry_nxt = key;
        end else if (IDX > tgt && IDX <= cnt) begin
          entry_nxt = left_entry;
        end
      end
      olie_pkg::CM_REMOVE: begin
        if (IDX >= tgt) begin
          entry_nxt = right_entry;
        end
      end
      olie_pkg::CM_MATCH: begin
        if (!right_sfx) begin
          entry_nxt = right_entry;
        end
      end
      olie_pkg::CM_HOLD: begin
        entry_nxt = entry_r;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // suffix OR scan: load, then fold in the neighbor 2^step cells above
  always_comb begin
    sflag_nxt = sflag_r;
    sdata_nxt = sdata_r;
    priority if (ctl.scan_load) begin
      if (ctl.match_scan) begin
        sflag_nxt = (entry_r == key) && (IDX < cnt);
        sdata_nxt = '0;
      end else begin
        sflag_nxt = (IDX == tgt);
        sdata_nxt = (IDX == tgt) ? entry_r : '0;
      end
    end else if (ctl.scan_step) begin
      sflag_nxt = sflag_r | nb_flag;
      sdata_nxt = sdata_r | nb_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    sflag_r <= sflag_nxt;
    sdata_r <= sdata_nxt;
  end

endmodule

### sv/olie_ctrl.sv
// Sequencer for the ordered list engine: count, request latch, scan steps,
// result registers and the per-cycle command to the cell chain. Uses olie_pkg.
`timescale 1ns / 1ps

module olie_ctrl #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [2:0]                         in_opcode,
  input  logic [6:0]                         in_position,
  input  logic [31:0]                        in_value,
  input  logic                               found,
  input  logic [ELEMENT_WIDTH-1:0]           found_data,
  output logic                               busy,
  output logic [((CAPACITY > 2) ? $clog2($clog2(CAPACITY)) : 1) - 1:0] step,
  output olie_pkg::cell_ctl_t                ctl,
  output logic [((($clog2(CAPACITY+1)) > 7) ? $clog2(CAPACITY+1) : 7) - 1:0] tgt,
  output logic [((($clog2(CAPACITY+1)) > 7) ? $clog2(CAPACITY+1) : 7) - 1:0] cnt,
  output logic [ELEMENT_WIDTH-1:0]           key,
  output logic                               out_valid,
  output logic [31:0]                        out_result_value,
  output logic [1:0]                         out_status,
  output logic [6:0]                         out_length
);

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = (CW > 7) ? CW : 7;
  localparam int unsigned STEPS = $clog2(CAPACITY);
  localparam int unsigned SW    = (CAPACITY > 2) ? $clog2(STEPS) : 1;
  localparam logic [PW-1:0] CAP_EXT = PW'(CAPACITY);

  olie_pkg::state_t  state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  olie_pkg::op_t     op_r;
  logic [6:0]        pos_r;
  logic [EW-1:0]     val_r;
  logic              ov_r, ov_nxt;
  logic [31:0]       res_r, res_nxt;
  olie_pkg::status_t st_r, st_nxt;
  logic [6:0]        len_r;

  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     pos_ext;
  olie_pkg::op_t     op_in;

  assign cnt_ext = PW'(cnt_r);
  assign pos_ext = PW'(pos_r);
  assign op_in   = olie_pkg::op_t'(in_opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olie_pkg::S_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == olie_pkg::S_IDLE && start) begin
      op_r  <= op_in;
      pos_r <= in_position;
      val_r <= EW'(in_value);
    end
    if (state_r == olie_pkg::S_APPLY) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
      len_r <= 7'(cnt_nxt);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = 1'b0;
    res_nxt   = '0;
    st_nxt    = olie_pkg::ST_ERR;
    ctl       = '{mode: olie_pkg::CM_HOLD, scan_load: 1'b0, scan_step: 1'b0,
                  match_scan: 1'b0};
    tgt       = pos_ext;
    key       = val_r;
    unique case (state_r)
      olie_pkg::S_IDLE: begin
        key = EW'(in_value);
        tgt = (op_in == olie_pkg::OP_POP_BACK) ? (cnt_ext - PW'(1)) : PW'(in_position);
        if (start) begin
          ctl.scan_load  = 1'b1;
          ctl.match_scan = (op_in == olie_pkg::OP_REMOVE_MATCH);
          state_nxt      = olie_pkg::S_SCAN;
          step_nxt       = '0;
        end
      end
      olie_pkg::S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (step_r == SW'(STEPS - 1)) begin
          state_nxt = olie_pkg::S_APPLY;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      olie_pkg::S_APPLY: begin
        state_nxt = olie_pkg::S_IDLE;
        ov_nxt    = 1'b1;
        unique case (op_r)
          olie_pkg::OP_INSERT: begin
            if (pos_ext <= cnt_ext && cnt_ext < CAP_EXT) begin
              ctl.mode = olie_pkg::CM_INSERT;
              tgt      = pos_ext;
              cnt_nxt  = cnt_r + CW'(1);
              st_nxt   = olie_pkg::ST_OK;
            end
          end
          olie_pkg::OP_PUSH_BACK: begin
            if (cnt_ext < CAP_EXT) begin
              ctl.mode = olie_pkg::CM_INSERT;
              tgt      = cnt_ext;
              cnt_nxt  = cnt_r + CW'(1);
              st_nxt   = olie_pkg::ST_OK;
            end
          end
          olie_pkg::OP_REMOVE_AT: begin
            if (pos_ext < cnt_ext) begin
              ctl.mode = olie_pkg::CM_REMOVE;
              tgt      = pos_ext;
              cnt_nxt  = cnt_r - CW'(1);
              res_nxt  = 32'(found_data);
              st_nxt   = olie_pkg::ST_OK;
            end
          end
          olie_pkg::OP_READ_AT: begin
            if (pos_ext < cnt_ext) begin
              res_nxt = 32'(found_data);
              st_nxt  = olie_pkg::ST_OK;
            end
          end
          olie_pkg::OP_POP_BACK: begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CW'(1);
              res_nxt = 32'(found_data);
              st_nxt  = olie_pkg::ST_OK;
            end
          end
          olie_pkg::OP_REMOVE_MATCH: begin
            if (found) begin
              ctl.mode = olie_pkg::CM_MATCH;
              cnt_nxt  = cnt_r - CW'(1);
              res_nxt  = 32'(val_r);
              st_nxt   = olie_pkg::ST_OK;
            end else begin
              st_nxt = olie_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            st_nxt = olie_pkg::ST_ERR;
          end
        endcase
      end
      default: begin
        state_nxt = olie_pkg::S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != olie_pkg::S_IDLE);
  assign step             = step_r;
  assign cnt              = cnt_ext;
  assign out_valid        = ov_r;
  assign out_result_value = res_r;
  assign out_status       = st_r;
  assign out_length       = len_r;

endmodule

### sv/ordered_list_insert_remove_engine_top.sv
// Top level of the ordered list engine: sequencer plus a chain of list cells.
// Depends on olie_pkg, olie_cell and olie_ctrl.
//
//   channel   handshake               payload
//   request   start / busy            in_opcode, in_position, in_value
//   result    out_valid (strobe)      out_result_value, out_status, out_length
//
// The transfer edge loads the scan words, the scan state runs the suffix-OR scan
// along the cell chain and the apply state shifts the chain and registers the result,
// raising the strobe. busy drops with it, so a new request is taken only once the
// last result is out. Reset clears the count; entries are undefined until written.
// The result shows for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module ordered_list_insert_remove_engine_top #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [2:0]  in_opcode,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        busy,
  output logic        out_valid,
  output logic [31:0] out_result_value,
  output logic [1:0]  out_status,
  output logic [6:0]  out_length
);

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = (CW > 7) ? CW : 7;
  localparam int unsigned STEPS = $clog2(CAPACITY);
  localparam int unsigned SW    = (CAPACITY > 2) ? $clog2(STEPS) : 1;
  localparam int unsigned NB    = 2 ** SW;

  olie_pkg::cell_ctl_t ctl;
  logic [SW-1:0]       step;
  logic [PW-1:0]       tgt;
  logic [PW-1:0]       cnt;
  logic [EW-1:0]       key;

  logic [EW-1:0] entry [CAPACITY];
  logic          sflag [CAPACITY];
  logic [EW-1:0] sdata [CAPACITY];

  olie_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_value         (in_value),
    .found            (sflag[0]),
    .found_data       (sdata[0]),
    .busy             (busy),
    .step             (step),
    .ctl              (ctl),
    .tgt              (tgt),
    .cnt              (cnt),
    .key              (key),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_length       (out_length)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [EW-1:0] left_e;
    logic [EW-1:0] right_e;
    logic          right_f;
    logic          cand_f [NB];
    logic [EW-1:0] cand_d [NB];

    if (k == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_left
      assign left_e = entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_f = 1'b0;
    end else begin : g_right
      assign right_e = entry[k+1];
      assign right_f = sflag[k+1];
    end

    // scan neighbor 2^i cells above, chosen by step
    for (genvar i = 0; i < NB; i++) begin : g_nb
      if (i < STEPS && k + (2 ** i) < CAPACITY) begin : g_on
        assign cand_f[i] = sflag[k + (2 ** i)];
        assign cand_d[i] = sdata[k + (2 ** i)];
      end else begin : g_off
        assign cand_f[i] = 1'b0;
        assign cand_d[i] = '0;
      end
    end

    olie_cell #(
      .K  (k),
      .EW (EW),
      .PW (PW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .tgt         (tgt),
      .cnt         (cnt),
      .key         (key),
      .left_entry  (left_e),
      .right_entry (right_e),
      .right_sfx   (right_f),
      .nb_flag     (cand_f[step]),
      .nb_data     (cand_d[step]),
      .entry_r     (entry[k]),
      .sflag_r     (sflag[k]),
      .sdata_r     (sdata[k])
    );
  end

endmodule

### sv/olie_checker.sv
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module olie_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `CHK_ALWAYS(a_reset_quiet, !rst_n |=> !busy && !out_valid)
  `CHK_ACTIVE(a_transfer_busy, start && !busy |=> busy)
  `CHK_ACTIVE(a_result_after_work, out_valid |-> $past(busy))
  `CHK_ACTIVE(a_done_gives_result, $fell(busy) |-> out_valid)

endmodule

bind ordered_list_insert_remove_engine_top olie_checker u_olie_checker (.*);

### dv/ordered_list_insert_remove_engine_top_tb.sv
// Self-checking testbench for ordered_list_insert_remove_engine_top: directed, fill/drain
// and random request streams checked against an internal list predictor.
// Depends on olie_pkg and the engine top level.
`timescale 1ns / 1ps

module ordered_list_insert_remove_engine_top_tb;

  localparam int CAP = 64;
  localparam logic [2:0] OPC_UNUSED_LO = 3'd6;
  localparam logic [2:0] OPC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0]       value;
    olie_pkg::status_t status;
    logic [6:0]        length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_opcode = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic [1:0]  out_status;
  logic [6:0]  out_length;

  logic [31:0]  list_mem [0:CAP-1];
  int unsigned  list_len = 0;
  list_result_t expected_results [$];

  bit idle_enable = 1'b1;
  int requests_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int full_rejects = 0;
  int match_misses = 0;

  ordered_list_insert_remove_engine_top #(
    .CAPACITY(CAP),
    .ELEMENT_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_opcode(in_opcode),
    .in_position(in_position),
    .in_value(in_value),
    .busy(busy),
    .out_valid(out_valid),
    .out_result_value(out_result_value),
    .out_status(out_status),
    .out_length(out_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] take_entry(int unsigned idx);
    logic [31:0] v;
    v = list_mem[idx];
    for (int k = idx; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
    list_len--;
    return v;
  endfunction

  function automatic list_result_t predict_list_op(logic [2:0] op, logic [6:0] pos,
                                                   logic [31:0] val);
    list_result_t r;
    r.value = '0;
    r.status = olie_pkg::ST_ERR;
    case (op)
      olie_pkg::OP_INSERT: begin
        if (pos <= list_len && list_len < CAP) begin
          for (int k = list_len; k > pos; k--) list_mem[k] = list_mem[k - 1];
          list_mem[pos] = val;
          list_len++;
          r.status = olie_pkg::ST_OK;
        end else if (list_len == CAP) begin
          full_rejects++;
        end
      end
      olie_pkg::OP_REMOVE_AT: begin
        if (pos < list_len) begin
          r.value = take_entry(pos);
          r.status = olie_pkg::ST_OK;
        end
      end
      olie_pkg::OP_READ_AT: begin
        if (pos < list_len) begin
          r.value = list_mem[pos];
          r.status = olie_pkg::ST_OK;
        end
      end
      olie_pkg::OP_PUSH_BACK: begin
        if (list_len < CAP) begin
          list_mem[list_len] = val;
          list_len++;
          r.status = olie_pkg::ST_OK;
        end else begin
          full_rejects++;
        end
      end
      olie_pkg::OP_POP_BACK: begin
        if (list_len > 0) begin
          list_len--;
          r.value = list_mem[list_len];
          r.status = olie_pkg::ST_OK;
        end
      end
      olie_pkg::OP_REMOVE_MATCH: begin
        r.status = olie_pkg::ST_NOTFOUND;
        for (int k = list_len; k > 0; k--) begin
          if (list_mem[k - 1] == val) begin
            r.value = take_entry(k - 1);
            r.status = olie_pkg::ST_OK;
            break;
          end
        end
        if (r.status == olie_pkg::ST_NOTFOUND) match_misses++;
      end
      default: begin
      end
    endcase
    r.length = list_len[6:0];
    return r;
  endfunction

  // start stays high from one transfer to the next unless an idle gap is taken
  task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                              input logic [31:0] val);
    if (idle_enable && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_opcode <= op;
    in_position <= pos;
    in_value <= val;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(predict_list_op(op, pos, val));
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_result_value, '0);
      end else begin
        list_result_t want;
        want = expected_results.pop_front();
        if (out_result_value !== want.value)
          report_mismatch("result_value", out_result_value, want.value);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_length !== want.length)
          report_mismatch("length", 32'(out_length), 32'(want.length));
      end
    end
  end

  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(olie_pkg::OP_READ_AT, 7'd0, 32'h0);
    send_request(olie_pkg::OP_POP_BACK, 7'd0, 32'h0);
    send_request(olie_pkg::OP_REMOVE_AT, 7'd0, 32'h0);
    send_request(olie_pkg::OP_REMOVE_MATCH, 7'd0, 32'h0);
    send_request(olie_pkg::OP_INSERT, 7'd1, 32'h1111_1111);
    send_request(olie_pkg::OP_INSERT, 7'd0, 32'h0000_0000);
    send_request(olie_pkg::OP_PUSH_BACK, 7'd127, 32'hFFFF_FFFF);
    send_request(olie_pkg::OP_INSERT, 7'd2, 32'h8000_0001);
    send_request(olie_pkg::OP_INSERT, 7'd1, 32'h5A5A_A5A5);
    send_request(olie_pkg::OP_INSERT, 7'd127, 32'h0000_0001);
    for (int i = 0; i < 4; i++) send_request(olie_pkg::OP_READ_AT, 7'(i), 32'h0);
    send_request(olie_pkg::OP_READ_AT, 7'd4, 32'h0);
    send_request(olie_pkg::OP_READ_AT, 7'd127, 32'h0);
    send_request(olie_pkg::OP_PUSH_BACK, 7'd0, 32'hFFFF_FFFF);
    send_request(olie_pkg::OP_REMOVE_MATCH, 7'd0, 32'hFFFF_FFFF);
    send_request(olie_pkg::OP_REMOVE_MATCH, 7'd0, 32'h1234_5678);
    send_request(OPC_UNUSED_LO, 7'd0, 32'hDEAD_BEEF);
    send_request(OPC_UNUSED_HI, 7'd127, 32'hFFFF_FFFF);
    send_request(olie_pkg::OP_REMOVE_AT, 7'd1, 32'h0);
    send_request(olie_pkg::OP_REMOVE_AT, 7'd4, 32'h0);
    send_request(olie_pkg::OP_POP_BACK, 7'd0, 32'h0);
    send_request(olie_pkg::OP_READ_AT, 7'd0, 32'h0);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 2) == 0) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  task automatic test_fill_and_drain();
    while (list_len < CAP) begin
      case ($urandom_range(0, 3))
        0: send_request(olie_pkg::OP_PUSH_BACK, 7'($urandom_range(0, 127)), pick_value());
        1: send_request(olie_pkg::OP_READ_AT, 7'($urandom_range(0, list_len)), 32'h0);
        default: send_request(olie_pkg::OP_INSERT, 7'($urandom_range(0, list_len)),
                              pick_value());
      endcase
    end
    send_request(olie_pkg::OP_PUSH_BACK, 7'd0, $urandom);
    send_request(olie_pkg::OP_INSERT, 7'd0, $urandom);
    send_request(olie_pkg::OP_INSERT, 7'd64, $urandom);
    send_request(olie_pkg::OP_READ_AT, 7'd64, 32'h0);
    send_request(olie_pkg::OP_READ_AT, 7'd63, 32'h0);
    while (list_len > 0) begin
      case ($urandom_range(0, 3))
        0: send_request(olie_pkg::OP_POP_BACK, 7'($urandom_range(0, 127)), $urandom);
        1: send_request(olie_pkg::OP_REMOVE_MATCH, 7'd0,
                        list_mem[$urandom_range(0, list_len - 1)]);
        2: send_request(olie_pkg::OP_READ_AT, 7'($urandom_range(0, list_len)), 32'h0);
        default: send_request(olie_pkg::OP_REMOVE_AT,
                              7'($urandom_range(0, list_len - 1)), 32'h0);
      endcase
    end
    send_request(olie_pkg::OP_POP_BACK, 7'd0, 32'h0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_request(olie_pkg::OP_PUSH_BACK, 7'd0, $urandom);
    wait_results_drained();
    send_request(olie_pkg::OP_READ_AT, 7'd5, 32'h0);
    send_request(olie_pkg::OP_REMOVE_MATCH, 7'd0, list_mem[2]);
  endtask

  task automatic test_random_mix(input int n);
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    int          w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 22) op = olie_pkg::OP_INSERT;
      else if (w < 36) op = olie_pkg::OP_REMOVE_AT;
      else if (w < 54) op = olie_pkg::OP_READ_AT;
      else if (w < 70) op = olie_pkg::OP_PUSH_BACK;
      else if (w < 80) op = olie_pkg::OP_POP_BACK;
      else if (w < 96) op = olie_pkg::OP_REMOVE_MATCH;
      else op = ($urandom_range(0, 1) == 0) ? OPC_UNUSED_LO : OPC_UNUSED_HI;
      if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
      else if (op == olie_pkg::OP_INSERT) pos = 7'($urandom_range(0, list_len));
      else pos = 7'($urandom_range(0, list_len > 0 ? list_len - 1 : 0));
      val = pick_value();
      if (op == olie_pkg::OP_REMOVE_MATCH && list_len > 0 && $urandom_range(0, 9) < 7)
        val = list_mem[$urandom_range(0, list_len - 1)];
      send_request(op, pos, val);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_drain_pause();
    test_random_mix(1000);
    idle_enable = 1'b0;
    test_random_mix(300);
    test_fill_and_drain();
    idle_enable = 1'b1;
    test_random_mix(300);
    wait_results_drained();
    repeat (16) @(posedge clk);
    while (expected_results.size() != 0) begin
      list_result_t lost;
      lost = expected_results.pop_front();
      report_mismatch("missing result", '0, lost.value);
    end
    $display("covered %0d requests, %0d results checked, %0d full-store rejects,",
             requests_sent, results_seen, full_rejects);
    $display("%0d failed matches; %0d mismatches", match_misses, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/olie_pkg.sv
sv/olie_cell.sv
sv/olie_ctrl.sv
sv/ordered_list_insert_remove_engine_top.sv
sv/olie_checker.sv
dv/ordered_list_insert_remove_engine_top_tb.sv
